FILE: hw/rtl/msts_pkg.sv
// Shared types and constants for the multi-strategy target selector.
// Used by the controller, the datapath, the modulo unit and the top level.
`timescale 1ns / 1ps

package msts_pkg;

	localparam int MaxEntriesDef = 64;

	localparam int PrioW     = 16;
	localparam int LoadW     = 7;
	localparam int CapW      = 16;
	localparam int LocW      = 16;
	localparam int ModeW     = 3;
	localparam int IndexOutW = 6;
	localparam int RotW      = 32;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;

	// strategy codes
	localparam logic [ModeW-1:0] MODE_PRIO  = 3'd0;
	localparam logic [ModeW-1:0] MODE_LOAD  = 3'd1;
	localparam logic [ModeW-1:0] MODE_CAP   = 3'd2;
	localparam logic [ModeW-1:0] MODE_RR    = 3'd3;
	localparam logic [ModeW-1:0] MODE_LOCAL = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_STRATEGY  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOME_ID   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HOME_SET  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic take;       // fold the accepted entry into the running bests
		logic start_div;  // launch rotation_counter mod entry_count
		logic finish;     // load the result register and clear the list
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;   // result register holds a request not taken this cycle
		logic empty;      // no entry counted in the current list
		logic rr_mode;    // round robin strategy selected
		logic div_done;   // modulo result is ready
	} sts_t;

endpackage

FILE: hw/rtl/msts_mod_unit.sv
// Restoring modulo unit: 32-bit dividend by a small entry count, one bit per cycle.
// Depends on msts_pkg for the dividend width.
`timescale 1ns / 1ps

module msts_mod_unit #(
	parameter int CNT_W = 7,
	parameter int IDX_W = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [msts_pkg::RotW-1:0]  dividend,
	input  logic [CNT_W-1:0]           divisor,
	output logic                       done,
	output logic [IDX_W-1:0]           rem
);

	localparam int StepW = $clog2(msts_pkg::RotW);

	logic                      busy_q;
	logic                      done_q;
	logic [StepW-1:0]          step_q;
	logic [msts_pkg::RotW-1:0] dvd_q;
	logic [CNT_W-1:0]          rem_q;
	logic [CNT_W-1:0]          dsr_q;
	logic [CNT_W:0]            trial;
	logic [CNT_W:0]            diff;
	logic                      ge;

	assign trial = {rem_q, dvd_q[msts_pkg::RotW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(msts_pkg::RotW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[msts_pkg::RotW-2:0], 1'b0};
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[IDX_W-1:0];

endmodule

FILE: hw/rtl/msts_datapath.sv
// Datapath: configuration registers, running bests, rotation counter and result register.
// Depends on msts_pkg and msts_mod_unit; driven by msts_ctrl commands.
`timescale 1ns / 1ps

module msts_datapath #(
	parameter int MAX_ENTRIES = msts_pkg::MaxEntriesDef,
	parameter int CNT_W       = 7,
	parameter int IDX_W       = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msts_pkg::cmd_t                 cmd,
	output msts_pkg::sts_t                 sts,
	input  logic                           cfg_valid,
	input  logic [msts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [msts_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [msts_pkg::PrioW-1:0]     entry_priority,
	input  logic [msts_pkg::LoadW-1:0]     entry_load,
	input  logic [msts_pkg::CapW-1:0]      entry_capacity,
	input  logic [msts_pkg::LocW-1:0]      entry_locality_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [msts_pkg::IndexOutW-1:0] chosen_index
);

	logic [msts_pkg::ModeW-1:0] strategy_mode_q;
	logic [msts_pkg::LocW-1:0]  home_id_q;
	logic                       home_set_q;

	logic [CNT_W-1:0]           entry_count_q;
	logic [msts_pkg::PrioW-1:0] best_prio_q;
	logic [IDX_W-1:0]           best_prio_idx_q;
	logic [msts_pkg::LoadW-1:0] best_load_q;
	logic [IDX_W-1:0]           best_load_idx_q;
	logic [msts_pkg::CapW-1:0]  best_cap_q;
	logic [IDX_W-1:0]           best_cap_idx_q;
	logic [msts_pkg::PrioW-1:0] local_prio_q;
	logic [IDX_W-1:0]           local_idx_q;
	logic                       local_seen_q;
	logic [msts_pkg::RotW-1:0]  rot_q;

	logic                       out_valid_q;
	logic                       found_q;
	logic [msts_pkg::IndexOutW-1:0] index_q;

	logic                       first;
	logic                       room;
	logic [IDX_W-1:0]           cur_idx;
	logic                       empty;
	logic                       rr_mode;
	logic                       div_done;
	logic [IDX_W-1:0]           div_rem;
	logic [IDX_W-1:0]           pick;
	logic [IDX_W+msts_pkg::IndexOutW-1:0] pick_ext;

	assign first   = entry_count_q == '0;
	assign room    = entry_count_q < CNT_W'(MAX_ENTRIES);
	assign cur_idx = entry_count_q[IDX_W-1:0];
	assign empty   = first;
	assign rr_mode = strategy_mode_q == msts_pkg::MODE_RR;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_mode_q <= msts_pkg::MODE_PRIO;
			home_id_q       <= '0;
			home_set_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				msts_pkg::CFG_STRATEGY: strategy_mode_q <= cfg_data[msts_pkg::ModeW-1:0];
				msts_pkg::CFG_HOME_ID:  home_id_q       <= cfg_data[msts_pkg::LocW-1:0];
				msts_pkg::CFG_HOME_SET: home_set_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// running bests; entries past capacity are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			local_seen_q  <= 1'b0;
		end else if (cmd.finish) begin
			entry_count_q <= '0;
			local_seen_q  <= 1'b0;
		end else if (cmd.take && room) begin
			entry_count_q <= entry_count_q + 1'b1;
			if (entry_locality_id == home_id_q)
				local_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && room) begin
			if (first || entry_priority < best_prio_q) begin
				best_prio_q     <= entry_priority;
				best_prio_idx_q <= cur_idx;
			end
			if (first || entry_load < best_load_q) begin
				best_load_q     <= entry_load;
				best_load_idx_q <= cur_idx;
			end
			if (first || entry_capacity > best_cap_q) begin
				best_cap_q     <= entry_capacity;
				best_cap_idx_q <= cur_idx;
			end
			if (entry_locality_id == home_id_q &&
			    (!local_seen_q || entry_priority < local_prio_q)) begin
				local_prio_q <= entry_priority;
				local_idx_q  <= cur_idx;
			end
		end
	end

	msts_mod_unit #(
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_div),
		.dividend(rot_q),
		.divisor (entry_count_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_comb begin
		unique case (strategy_mode_q)
			msts_pkg::MODE_LOAD:  pick = best_load_idx_q;
			msts_pkg::MODE_CAP:   pick = best_cap_idx_q;
			msts_pkg::MODE_RR:    pick = div_rem;
			msts_pkg::MODE_LOCAL: pick = (home_set_q && local_seen_q) ? local_idx_q
			                                                          : best_prio_idx_q;
			default:              pick = best_prio_idx_q;
		endcase
	end

	assign pick_ext = {{msts_pkg::IndexOutW{1'b0}}, pick};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (rr_mode && !empty)
					rot_q <= rot_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= !empty;
			index_q <= empty ? '0 : pick_ext[msts_pkg::IndexOutW-1:0];
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign sts.empty    = empty;
	assign sts.rr_mode  = rr_mode;
	assign sts.div_done = div_done;

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign chosen_index = index_q;

endmodule

FILE: hw/rtl/msts_ctrl.sv
// Controller: accepts list items, then sequences result selection and the modulo unit.
// Depends on msts_pkg for the command and status structs.
`timescale 1ns / 1ps

module msts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           entry_present,
	input  logic           list_end,
	output msts_pkg::cmd_t cmd,
	input  msts_pkg::sts_t sts
);

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_PICK = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// a closing item waits only until the result register can take its request
	assign in_ready = (state_q == ST_ACC) && (!list_end || !sts.out_busy);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		cmd.take      = 1'b0;
		cmd.start_div = 1'b0;
		cmd.finish    = 1'b0;
		unique case (state_q)
			ST_ACC: begin
				cmd.take = accept && entry_present;
				if (accept && list_end)
					state_d = ST_PICK;
			end
			ST_PICK: begin
				if (sts.rr_mode && !sts.empty) begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_ACC;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_ACC;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	// a result is only loaded into a free output register
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("result loaded while output register busy");

	// modulo result shows up only while waiting for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("modulo done outside divide state");

	// launching a divide puts the controller in the divide state next cycle
	a_div_launch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> state_q == ST_DIV && !cmd.finish)
		else $error("divide launch did not reach divide state");
`endif

endmodule

FILE: hw/rtl/multi_strategy_target_selector.sv
// Multi-strategy target selector: top level joining controller and datapath.
// Usage:
//   Input channel (in_valid/in_ready) takes one candidate per request, with
//   entry_present and list_end; list_end closes the list. A request with
//   entry_present low and list_end high closes the list without an entry.
//   Output channel (out_valid/out_ready) gives one result per list: found and
//   chosen_index. Configuration channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) writes strategy_mode, home_locality_id, home_locality_set;
//   cfg_ready is always high, write only while idle.
// Flow:
//   Entries are taken one per cycle. The closing request is followed by a
//   selection state that loads the result register; no new request is taken
//   until it is loaded. For round robin with a non-empty list, that state
//   launches the bit-serial modulo unit instead, and the result register is
//   loaded once its remainder is done. A stalled receiver does not block
//   entries; only a closing request waits until the result register is free.
// Reset: configuration, the entry count, the locality flag and the rotation
//   counter clear; no result is pending.
// Depends on msts_pkg, msts_ctrl, msts_datapath, msts_mod_unit.
`timescale 1ns / 1ps

module multi_strategy_target_selector #(
	parameter int MAX_ENTRIES = msts_pkg::MaxEntriesDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [msts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [msts_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           entry_present,
	input  logic [msts_pkg::PrioW-1:0]     entry_priority,
	input  logic [msts_pkg::LoadW-1:0]     entry_load,
	input  logic [msts_pkg::CapW-1:0]      entry_capacity,
	input  logic [msts_pkg::LocW-1:0]      entry_locality_id,
	input  logic                           list_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [msts_pkg::IndexOutW-1:0] chosen_index
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	msts_pkg::cmd_t cmd;
	msts_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	msts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.entry_present(entry_present),
		.list_end     (list_end),
		.cmd          (cmd),
		.sts          (sts)
	);

	msts_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.entry_priority   (entry_priority),
		.entry_load       (entry_load),
		.entry_capacity   (entry_capacity),
		.entry_locality_id(entry_locality_id),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.chosen_index     (chosen_index)
	);

endmodule
